[design/ctu_pkg.sv]
// shared types, status codes and calendar table for the civil time to utc converter
package ctu_pkg;

    // result status
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FIELD_BAD = 2'd1,
        STATUS_YEAR_BAD  = 2'd2,
        STATUS_NONPOS    = 2'd3
    } ctu_status_t;

    // timezone sign modes (other codes mean offset zero)
    localparam logic [1:0] ZONE_PLUS  = 2'd1;
    localparam logic [1:0] ZONE_MINUS = 2'd2;

    // field limits
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] SECOND_MAX = 7'd60;
    // accepted years, as offsets from 2000
    localparam logic [6:0] YY_MIN = 7'd24;
    localparam logic [6:0] YY_MAX = 7'd69;

    // every accepted year sits in era five: 5 * 146097 - 719468
    localparam logic [15:0] ERA_DAY_BASE = 16'd11017;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic signed [17:0] SECS_PER_QUARTER = 18'sd900;

    // input transaction
    typedef struct packed {
        logic [6:0] year_two_digit;
        logic [6:0] month_num;
        logic [6:0] day_num;
        logic [6:0] hour_num;
        logic [6:0] minute_num;
        logic [6:0] second_num;
        logic [1:0] zone_mode;
        logic [6:0] zone_magnitude;
    } ctu_in_t;

    // result transaction
    typedef struct packed {
        ctu_status_t       status_code;
        logic [31:0]       utc_seconds;
        logic signed [7:0] zone_quarter_hours;
    } ctu_out_t;

    // decoded reading, first pipeline stage
    typedef struct packed {
        ctu_status_t       status;
        logic [6:0]        yoe;
        logic [8:0]        doy;
        logic [16:0]       hour_sec;
        logic [11:0]       min_sec;
        logic signed [7:0] zq;
    } ctu_dec_t;

    // days from 1 march to the first of the month, (153 * mp + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] off;
        begin
            case (mon)
                4'd1:    off = 9'd306;
                4'd2:    off = 9'd337;
                4'd3:    off = 9'd0;
                4'd4:    off = 9'd31;
                4'd5:    off = 9'd61;
                4'd6:    off = 9'd92;
                4'd7:    off = 9'd122;
                4'd8:    off = 9'd153;
                4'd9:    off = 9'd184;
                4'd10:   off = 9'd214;
                4'd11:   off = 9'd245;
                4'd12:   off = 9'd275;
                default: off = 9'd0;
            endcase
            month_offset = off;
        end
    endfunction

endpackage

[design/ctu_decode.sv]
// field checks, year window and first partial sums of the reading
module ctu_decode import ctu_pkg::*; (
    input  ctu_in_t  rd,
    output ctu_dec_t dec
);

    logic field_bad;
    logic year_bad;
    logic early_month;

    // range checks on the raw fields
    assign field_bad = (rd.month_num == 7'd0) || (rd.month_num > MONTH_MAX) ||
                       (rd.day_num == 7'd0) || (rd.day_num > DAY_MAX) ||
                       (rd.hour_num > HOUR_MAX) || (rd.minute_num > MINUTE_MAX) ||
                       (rd.second_num > SECOND_MAX);
    assign year_bad    = (rd.year_two_digit < YY_MIN) || (rd.year_two_digit > YY_MAX);
    assign early_month = (rd.month_num <= 7'd2);

    always_comb begin
        // status before the sign test
        if (field_bad) begin
            dec.status = STATUS_FIELD_BAD;
        end else if (year_bad) begin
            dec.status = STATUS_YEAR_BAD;
        end else begin
            dec.status = STATUS_OK;
        end

        // march-based year within the era and day within that year
        dec.yoe = rd.year_two_digit - {6'd0, early_month};
        dec.doy = month_offset(rd.month_num[3:0]) + {2'd0, rd.day_num} - 9'd1;

        // seconds of the day, split in two
        dec.hour_sec = 17'({10'd0, rd.hour_num} * SECS_PER_HOUR);
        dec.min_sec  = 12'({5'd0, rd.minute_num} * SECS_PER_MIN) + {5'd0, rd.second_num};

        // signed offset in quarter hours
        case (rd.zone_mode)
            ZONE_PLUS:  dec.zq = $signed({1'b0, rd.zone_magnitude});
            ZONE_MINUS: dec.zq = -$signed({1'b0, rd.zone_magnitude});
            default:    dec.zq = 8'sd0;
        endcase
    end

endmodule

[design/civil_time_to_utc_epoch_top.sv]
// An accepted input passes decode, day count, seconds and result registers.
// Throughput: one transaction per cycle unless m_ready stalls; each stage has
// its own valid bit and advances whenever the stage after it is empty or
// moving, so a stalled result holds only as far back as the pipeline is full.
// Reset: synchronous, active low aresetn clears only the stage valid bits.
module civil_time_to_utc_epoch_top import ctu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ctu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ctu_out_t m_data
);

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage one: decoded reading
    ctu_dec_t dec_next;
    ctu_dec_t dec_reg;

    // stage two: day count, time of day, zone seconds
    ctu_status_t       st2_reg;
    logic [15:0]       days_reg, days_next;
    logic [16:0]       tod_reg, tod_next;
    logic signed [17:0] zsec_reg, zsec_next;
    logic signed [7:0] zq2_reg;

    // stage three: seconds of whole days and the net seconds inside the day
    ctu_status_t        st3_reg;
    logic [31:0]        dsec_reg, dsec_next;
    logic signed [18:0] net_reg, net_next;
    logic signed [7:0]  zq3_reg;

    // stage four: result register
    ctu_out_t           out_reg, out_next;
    logic signed [33:0] utc_sum;

    // ready ripples back from the result side
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;
    assign m_data  = out_reg;

    ctu_decode u_decode (
        .rd  (s_data),
        .dec (dec_next)
    );

    // day count and second-level partial sums
    always_comb begin
        days_next = ERA_DAY_BASE + 16'({9'd0, dec_reg.yoe} * DAYS_PER_YEAR)
                  + {11'd0, dec_reg.yoe[6:2]} + {7'd0, dec_reg.doy};
        tod_next  = dec_reg.hour_sec + {5'd0, dec_reg.min_sec};
        zsec_next = 18'(dec_reg.zq * SECS_PER_QUARTER);
    end

    // whole days to seconds, offset taken off the time of day
    always_comb begin
        dsec_next = 32'({16'd0, days_reg} * SECS_PER_DAY);
        net_next  = $signed({2'b00, tod_reg}) - 19'(zsec_reg);
    end

    // final sum, sign test and masking of rejected readings
    always_comb begin
        utc_sum  = $signed({2'b00, dsec_reg}) + 34'(net_reg);
        out_next = '0;
        if (st3_reg != STATUS_OK) begin
            out_next.status_code = st3_reg;
        end else if (utc_sum[33] || (utc_sum == 34'sd0)) begin
            out_next.status_code = STATUS_NONPOS;
        end else begin
            out_next.status_code        = STATUS_OK;
            out_next.utc_seconds        = utc_sum[31:0];
            out_next.zone_quarter_hours = zq3_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            dec_reg <= dec_next;
        end
        if (rdy2) begin
            st2_reg  <= dec_reg.status;
            days_reg <= days_next;
            tod_reg  <= tod_next;
            zsec_reg <= zsec_next;
            zq2_reg  <= dec_reg.zq;
        end
        if (rdy3) begin
            st3_reg  <= st2_reg;
            dsec_reg <= dsec_next;
            net_reg  <= net_next;
            zq3_reg  <= zq2_reg;
        end
        if (rdy4) begin
            out_reg <= out_next;
        end
    end

endmodule

[design/ctu_checker.sv]
// port-level checks for the civil time to utc converter, bound to the top level
module ctu_checker import ctu_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ctu_out_t m_data
);

    // nothing comes out in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // rejected readings carry zero time and zero offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status_code != STATUS_OK) |->
        (m_data.utc_seconds == 32'd0) && (m_data.zone_quarter_hours == 8'sd0))
        else $error("rejected result has nonzero payload");

    // an accepted result is a positive time with an offset of magnitude below 128
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status_code == STATUS_OK) |->
        (m_data.utc_seconds != 32'd0) && (m_data.zone_quarter_hours != -8'sd128))
        else $error("accepted result out of range");

    // an empty pipeline with a free output side takes input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && m_ready && !$past(s_valid) && !$past(s_valid, 2) &&
        !$past(s_valid, 3) && !$past(s_valid, 4) && $past(aresetn, 4) |-> s_ready)
        else $error("input held off while pipeline empty");

endmodule

bind civil_time_to_utc_epoch_top ctu_checker u_ctu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/utc_result_checker.sv]
// checker that predicts and compares the converter's utc results on both channels
module utc_result_checker import ctu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ctu_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ctu_out_t m_data,
    output int       fail_count,
    output int       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint YEAR_BASE       = 2000;
    localparam longint DAYS_IN_ERA     = 146097;
    localparam longint EPOCH_DAY_SHIFT = 719468;
    localparam longint DAY_SECONDS     = 86400;
    localparam longint HOUR_SECONDS    = 3600;
    localparam longint MINUTE_SECONDS  = 60;
    localparam longint QUARTER_SECONDS = 900;
    localparam int     REPORT_LIMIT    = 10;

    ctu_out_t expected_utc_q[$];

    // expected result for one clock reading
    function automatic ctu_out_t predict_utc_result(input ctu_in_t rd);
        ctu_out_t res;
        longint   year_full;
        longint   mon;
        longint   yr_adj;
        longint   era;
        longint   yoe;
        longint   mp;
        longint   doy;
        longint   doe;
        longint   day_count;
        longint   local_secs;
        longint   utc_secs;
        longint   zq;
        res = '0;
        res.status_code = STATUS_OK;
        // field limits come first
        if (rd.month_num < 7'd1 || rd.month_num > MONTH_MAX ||
                rd.day_num < 7'd1 || rd.day_num > DAY_MAX ||
                rd.hour_num > HOUR_MAX || rd.minute_num > MINUTE_MAX ||
                rd.second_num > SECOND_MAX) begin
            res.status_code = STATUS_FIELD_BAD;
            return res;
        end
        // then the year window
        if (rd.year_two_digit < YY_MIN || rd.year_two_digit > YY_MAX) begin
            res.status_code = STATUS_YEAR_BAD;
            return res;
        end
        // signed offset, unused modes give zero
        if (rd.zone_mode == ZONE_PLUS)
            zq = longint'(rd.zone_magnitude);
        else if (rd.zone_mode == ZONE_MINUS)
            zq = -longint'(rd.zone_magnitude);
        else
            zq = 0;
        // days from civil, march-based years
        year_full = YEAR_BASE + longint'(rd.year_two_digit);
        mon = longint'(rd.month_num);
        yr_adj = (mon <= 2) ? year_full - 1 : year_full;
        era = yr_adj / 400;
        yoe = yr_adj - era * 400;
        mp = (mon > 2) ? mon - 3 : mon + 9;
        doy = (153 * mp + 2) / 5 + longint'(rd.day_num) - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        day_count = era * DAYS_IN_ERA + doe - EPOCH_DAY_SHIFT;
        local_secs = day_count * DAY_SECONDS
                   + longint'(rd.hour_num) * HOUR_SECONDS
                   + longint'(rd.minute_num) * MINUTE_SECONDS
                   + longint'(rd.second_num);
        utc_secs = local_secs - zq * QUARTER_SECONDS;
        if (utc_secs <= 0) begin
            res.status_code = STATUS_NONPOS;
            return res;
        end
        res.utc_seconds = utc_secs[31:0];
        res.zone_quarter_hours = zq[7:0];
        return res;
    endfunction

    // record readings going in, compare results coming out
    always @(posedge aclk) begin
        ctu_out_t exp_res;
        if (!aresetn) begin
            fail_count = 0;
            pending_count = 0;
            expected_utc_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_utc_q.push_back(predict_utc_result(s_data));
            if (m_valid && m_ready) begin
                if (expected_utc_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result transaction with none expected: status %0d utc %0d zone %0d",
                                 $realtime, m_data.status_code, m_data.utc_seconds,
                                 m_data.zone_quarter_hours);
                end else begin
                    exp_res = expected_utc_q.pop_front();
                    if (m_data.status_code !== exp_res.status_code ||
                            m_data.utc_seconds !== exp_res.utc_seconds ||
                            m_data.zone_quarter_hours !== exp_res.zone_quarter_hours) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: status %0d/%0d utc %0d/%0d zone %0d/%0d (exp/act)",
                                     $realtime, exp_res.status_code, m_data.status_code,
                                     exp_res.utc_seconds, m_data.utc_seconds,
                                     exp_res.zone_quarter_hours, m_data.zone_quarter_hours);
                    end
                end
            end
            pending_count = expected_utc_q.size();
        end
    end

endmodule

[sim/civil_time_to_utc_epoch_top_test.sv]
// stimulus, clock, reset and verdict for the civil time to utc converter
module civil_time_to_utc_epoch_top_test;
    import ctu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ZONE_NONE  = 2'd0;
    localparam logic [1:0] ZONE_SPARE = 2'd3;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 333;
    localparam int DRAIN_CYCLES    = 8;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ctu_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ctu_out_t m_data;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    civil_time_to_utc_epoch_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utc_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if (!aresetn)
            quiet_cycles <= 0;
        else if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic ctu_in_t make_reading(input int yy, input int mo, input int dd,
                                             input int hh, input int mi, input int ss,
                                             input logic [1:0] zm, input int mag);
        ctu_in_t rd;
        rd.year_two_digit = yy[6:0];
        rd.month_num      = mo[6:0];
        rd.day_num        = dd[6:0];
        rd.hour_num       = hh[6:0];
        rd.minute_num     = mi[6:0];
        rd.second_num     = ss[6:0];
        rd.zone_mode      = zm;
        rd.zone_magnitude = mag[6:0];
        return rd;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_reading(input ctu_in_t rd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= rd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender stays idle until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    initial begin
        ctu_in_t rd;
        int      kind;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 35;
        recv_idle_pct = 88;
        aresetn = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: window edges, calendar roll-over, zone modes, bad fields
        send_reading(make_reading(24, 1, 1, 0, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(69, 12, 31, 23, 59, 60, ZONE_PLUS, 127));
        send_reading(make_reading(69, 12, 31, 23, 59, 59, ZONE_MINUS, 127));
        send_reading(make_reading(24, 2, 31, 12, 30, 30, ZONE_PLUS, 4));
        send_reading(make_reading(25, 2, 31, 0, 0, 0, ZONE_MINUS, 20));
        send_reading(make_reading(24, 3, 1, 0, 0, 0, ZONE_NONE, 99));
        send_reading(make_reading(40, 6, 15, 8, 59, 60, ZONE_PLUS, 36));
        send_reading(make_reading(50, 7, 4, 11, 11, 11, ZONE_SPARE, 50));
        send_reading(make_reading(24, 1, 1, 0, 0, 0, ZONE_PLUS, 127));
        send_reading(make_reading(0, 0, 1, 0, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 13, 1, 0, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 5, 0, 0, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 5, 32, 0, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 5, 10, 24, 0, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 5, 10, 0, 60, 0, ZONE_NONE, 0));
        send_reading(make_reading(30, 5, 10, 0, 0, 61, ZONE_NONE, 0));
        send_reading(make_reading(127, 127, 127, 127, 127, 127, ZONE_SPARE, 127));
        send_reading(make_reading(23, 12, 31, 23, 59, 59, ZONE_MINUS, 8));
        send_reading(make_reading(70, 1, 1, 0, 0, 0, ZONE_PLUS, 8));
        send_reading(make_reading(0, 6, 6, 6, 6, 6, ZONE_NONE, 0));
        send_reading(make_reading(127, 6, 6, 6, 6, 6, ZONE_MINUS, 1));

        // hold off until the pipeline is empty
        wait_drained();

        // random phases: sender busy/receiver slow, then swapped, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 35 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // mostly well-formed readings with random content
                rd = make_reading($urandom_range(24, 69), $urandom_range(1, 12),
                                  $urandom_range(1, 31), $urandom_range(0, 23),
                                  $urandom_range(0, 59), $urandom_range(0, 60),
                                  2'($urandom_range(0, 3)), $urandom_range(0, 127));
                kind = $urandom_range(99);
                if (kind >= 93) begin
                    // year outside the window
                    rd.year_two_digit = ($urandom_range(1) != 0) ?
                        7'($urandom_range(0, 23)) : 7'($urandom_range(70, 127));
                end else if (kind >= 85) begin
                    // one field broken
                    case ($urandom_range(5))
                        0: rd.month_num = ($urandom_range(1) != 0) ?
                               7'd0 : 7'($urandom_range(13, 127));
                        1: rd.day_num = ($urandom_range(1) != 0) ?
                               7'd0 : 7'($urandom_range(32, 127));
                        2: rd.hour_num = 7'($urandom_range(24, 127));
                        3: rd.minute_num = 7'($urandom_range(60, 127));
                        default: rd.second_num = 7'($urandom_range(61, 127));
                    endcase
                end else if (kind >= 75) begin
                    // raw noise over every bit
                    rd = ctu_in_t'(51'({$urandom, $urandom}));
                end
                send_reading(rd);
            end
            wait_drained();
        end
        s_valid <= 1'b0;

        // let anything late show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/ctu_pkg.sv
design/ctu_decode.sv
design/civil_time_to_utc_epoch_top.sv
design/ctu_checker.sv
sim/utc_result_checker.sv
sim/civil_time_to_utc_epoch_top_test.sv
